// ----- rtl/hwr_pkg.sv -----
// ----------------------------------------------------------------------------
// hwr_pkg: shared types and constants for the hue wheel to RGB converter.
// Fixed-point widths, the full-scale constants and the sector codes.
// ----------------------------------------------------------------------------
package hwr_pkg;

    // Hue is a fraction of a full turn, saturation and brightness are Q12.
    localparam int HUE_BITS  = 16;
    localparam int FRAC_BITS = 12;

    // Port widths of the fields.
    localparam int HUE_W = 16;
    localparam int SV_W  = 13;
    localparam int CH_W  = 16;

    // Internal widths.
    localparam int FAC_W  = FRAC_BITS + 1;           // factor, 0 .. ONE_Q
    localparam int P_W    = HUE_BITS + 3;            // hue * 6
    localparam int WT_W   = HUE_BITS + 1;            // ramp weight, 0 .. TURN
    localparam int WS_W   = WT_W + FAC_W;            // weight * saturation
    localparam int CV_W   = CH_W + FAC_W;            // channel_max * factor
    localparam int PROD_W = CV_W + FAC_W;            // ... * brightness

    // Register stages from an accepted item to its result.
    localparam int STAGES = 4;

    localparam logic [FAC_W-1:0] ONE_Q = FAC_W'(2 ** FRAC_BITS);
    localparam logic [WT_W-1:0]  TURN  = WT_W'(2 ** HUE_BITS);

    localparam logic [CH_W-1:0] CHANNEL_MAX_RESET = CH_W'(255);

    // One 60 degree sector of the wheel.
    typedef enum logic [2:0] {
        SEC_RED_GREEN  = 3'd0,
        SEC_GREEN_RED  = 3'd1,
        SEC_GREEN_BLUE = 3'd2,
        SEC_BLUE_GREEN = 3'd3,
        SEC_BLUE_RED   = 3'd4,
        SEC_RED_BLUE   = 3'd5
    } t_sector;

endpackage

// ----- rtl/hue_wheel_to_rgb_unit.sv -----
// ----------------------------------------------------------------------------
// hue_wheel_to_rgb_unit: hue wheel point to RGBA converter.
// Takes one item (hue, saturation, brightness) per clock and returns red,
// green, blue and alpha. A new item is taken every cycle as long as the
// output side takes results; a stall on the output holds the whole
// four-stage pipeline in place. The stages are the sector decode, the ramp
// multiply and the two channel multiplies. The full-scale value (reset 255)
// is written on the configuration channel; the user writes it only while
// the unit is idle, not enforced by the unit. Alpha always reads it back.
// ----------------------------------------------------------------------------
module hue_wheel_to_rgb_unit import hwr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CH_W-1:0]  i_cfg_data,
    // Input items.
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [SV_W-1:0]  i_saturation,
    input  logic [SV_W-1:0]  i_brightness,
    // Result items.
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue,
    output logic [CH_W-1:0]  o_alpha
);

    logic [CH_W-1:0]   r_channel_max;
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic              en;
    logic [FAC_W-1:0]  fac_red;
    logic [FAC_W-1:0]  fac_green;
    logic [FAC_W-1:0]  fac_blue;
    logic [FAC_W-1:0]  v;

    // The pipeline moves whenever the last stage is empty or being taken.
    assign en      = ~r_vld[STAGES-1] | i_ready;
    assign o_ready = en;
    assign n_vld   = {r_vld[STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    // Full-scale register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_max <= CHANNEL_MAX_RESET;
        end else if (i_cfg_valid) begin
            r_channel_max <= i_cfg_data;
        end
    end

    // Stages 1 and 2.
    hwr_sector u_sector (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_fac_red    (fac_red),
        .o_fac_green  (fac_green),
        .o_fac_blue   (fac_blue),
        .o_v          (v)
    );

    // Stages 3 and 4, one per channel.
    hwr_scale u_scale_red (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_channel_max (r_channel_max),
        .i_fac         (fac_red),
        .i_v           (v),
        .o_chan        (o_red)
    );

    hwr_scale u_scale_green (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_channel_max (r_channel_max),
        .i_fac         (fac_green),
        .i_v           (v),
        .o_chan        (o_green)
    );

    hwr_scale u_scale_blue (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_channel_max (r_channel_max),
        .i_fac         (fac_blue),
        .i_v           (v),
        .o_chan        (o_blue)
    );

    assign o_valid = r_vld[STAGES-1];
    assign o_alpha = r_channel_max;

endmodule

// ----- rtl/hwr_sector.sv -----
// ----------------------------------------------------------------------------
// hwr_sector: sector decode and per-channel color factors.
// Two register stages: hue to sector and ramp weight, then the ramp product
// and the routing of full, low and ramp factors to red, green and blue.
// ----------------------------------------------------------------------------
module hwr_sector import hwr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [HUE_W-1:0] i_hue,
    input  logic [SV_W-1:0]  i_saturation,
    input  logic [SV_W-1:0]  i_brightness,
    output logic [FAC_W-1:0] o_fac_red,
    output logic [FAC_W-1:0] o_fac_green,
    output logic [FAC_W-1:0] o_fac_blue,
    output logic [FAC_W-1:0] o_v
);

    logic [P_W-1:0]      p;
    logic [HUE_BITS-1:0] frac;
    logic [FAC_W-1:0]    n_s;
    logic [FAC_W-1:0]    n_v1;
    logic [WT_W-1:0]     n_w;
    t_sector             n_sector;

    t_sector             r_sector;
    logic [WT_W-1:0]     r_w;
    logic [FAC_W-1:0]    r_s;
    logic [FAC_W-1:0]    r_v1;

    logic [WS_W-1:0]     ws;
    logic [FAC_W-1:0]    low;
    logic [FAC_W-1:0]    ramp;
    logic [FAC_W-1:0]    n_fac_red;
    logic [FAC_W-1:0]    n_fac_green;
    logic [FAC_W-1:0]    n_fac_blue;

    logic [FAC_W-1:0]    r_fac_red;
    logic [FAC_W-1:0]    r_fac_green;
    logic [FAC_W-1:0]    r_fac_blue;
    logic [FAC_W-1:0]    r_v2;

    // Stage 1: clamp, scale the hue by six and split off the sector.
    always_comb begin
        p        = (P_W'(i_hue[HUE_BITS-1:0]) << 2) + (P_W'(i_hue[HUE_BITS-1:0]) << 1);
        frac     = p[HUE_BITS-1:0];
        n_sector = t_sector'(p[P_W-1:HUE_BITS]);
        n_s      = (i_saturation > ONE_Q) ? ONE_Q : i_saturation;
        n_v1     = (i_brightness > ONE_Q) ? ONE_Q : i_brightness;
        // The channel rises in even sectors and falls in odd ones.
        if (p[HUE_BITS] == 1'b0) begin
            n_w = TURN - WT_W'(frac);
        end else begin
            n_w = WT_W'(frac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sector <= n_sector;
            r_w      <= n_w;
            r_s      <= n_s;
            r_v1     <= n_v1;
        end
    end

    // Stage 2: ramp factor and the routing of the three factors.
    always_comb begin
        ws   = WS_W'(r_w) * WS_W'(r_s);
        low  = ONE_Q - r_s;
        ramp = ONE_Q - ws[HUE_BITS +: FAC_W];
        case (r_sector)
            SEC_RED_GREEN: begin
                n_fac_red = ONE_Q; n_fac_green = ramp;  n_fac_blue = low;
            end
            SEC_GREEN_RED: begin
                n_fac_red = ramp;  n_fac_green = ONE_Q; n_fac_blue = low;
            end
            SEC_GREEN_BLUE: begin
                n_fac_red = low;   n_fac_green = ONE_Q; n_fac_blue = ramp;
            end
            SEC_BLUE_GREEN: begin
                n_fac_red = low;   n_fac_green = ramp;  n_fac_blue = ONE_Q;
            end
            SEC_BLUE_RED: begin
                n_fac_red = ramp;  n_fac_green = low;   n_fac_blue = ONE_Q;
            end
            default: begin
                n_fac_red = ONE_Q; n_fac_green = low;   n_fac_blue = ramp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fac_red   <= n_fac_red;
            r_fac_green <= n_fac_green;
            r_fac_blue  <= n_fac_blue;
            r_v2        <= r_v1;
        end
    end

    assign o_fac_red   = r_fac_red;
    assign o_fac_green = r_fac_green;
    assign o_fac_blue  = r_fac_blue;
    assign o_v         = r_v2;

endmodule

// ----- rtl/hwr_scale.sv -----
// ----------------------------------------------------------------------------
// hwr_scale: scales one channel factor to the output range.
// Two register stages: channel_max times factor, then times brightness,
// truncated back to the channel width.
// ----------------------------------------------------------------------------
module hwr_scale import hwr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [CH_W-1:0]  i_channel_max,
    input  logic [FAC_W-1:0] i_fac,
    input  logic [FAC_W-1:0] i_v,
    output logic [CH_W-1:0]  o_chan
);

    logic [CV_W-1:0]   r_cv;
    logic [FAC_W-1:0]  r_v;
    logic [PROD_W-1:0] prod;
    logic [CH_W-1:0]   r_chan;

    // Stage 3: full-scale value times the color factor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cv <= CV_W'(i_channel_max) * CV_W'(i_fac);
            r_v  <= i_v;
        end
    end

    // Stage 4: times brightness, drop both fraction parts.
    assign prod = PROD_W'(r_cv) * PROD_W'(r_v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= prod[2*FRAC_BITS +: CH_W];
        end
    end

    assign o_chan = r_chan;

endmodule
